### rtl/alrm_pkg.sv
// Shared types, constants and helpers for the autoranging link rate meter.
`timescale 1ns / 1ps
package alrm_pkg;

    localparam int unsigned RATE_W   = 64;
    localparam int unsigned MINPK_W  = 41;
    localparam int unsigned SHIFT_W  = 5;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned SEL_W    = 4;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned PROD_W   = 72;
    localparam int unsigned DSTEP_W  = 7;
    localparam logic [DSTEP_W-1:0] DIV_STEPS = 7'd72;
    localparam logic [CNT_W-1:0]   MAX_RESULTS = 7'd64;
    localparam logic [RATE_W-1:0]  DECAY_FLOOR = 64'd1024;
    localparam logic [MINPK_W-1:0] MIN_PEAK_RST = 41'd1048576;
    localparam logic [SHIFT_W-1:0] DECAY_RST = 5'd7;

    localparam logic [RATE_W-1:0] KB_BYTES = 64'd1024;
    localparam logic [RATE_W-1:0] MB_BYTES = 64'd1048576;
    localparam logic [RATE_W-1:0] GB_BYTES = 64'd1073741824;

    typedef enum logic [1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_REGEN    = 2'd1,
        CMD_BASELINE = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_MIN_PEAK    = 1'b0,
        CFG_DECAY_SHIFT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_PEAK,
        S_FLOOR,
        S_RLOAD,
        S_RWAIT,
        S_DSTART,
        S_DWAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

    function automatic logic [SEL_W-1:0] ceil_index(input logic [RATE_W-1:0] v);
        logic [SEL_W-1:0] idx;
        idx = 4'd8;
        if (v <= 64'd100 * GB_BYTES) idx = 4'd8;
        if (v <= 64'd10 * GB_BYTES)  idx = 4'd7;
        if (v <= GB_BYTES)           idx = 4'd6;
        if (v <= 64'd100 * MB_BYTES) idx = 4'd5;
        if (v <= 64'd10 * MB_BYTES)  idx = 4'd4;
        if (v <= MB_BYTES)           idx = 4'd3;
        if (v <= 64'd100 * KB_BYTES) idx = 4'd2;
        if (v <= 64'd10 * KB_BYTES)  idx = 4'd1;
        if (v <= KB_BYTES)           idx = 4'd0;
        return idx;
    endfunction

endpackage

### rtl/alrm_if.sv
// Valid/ready channel interfaces for input items and results.
`timescale 1ns / 1ps
interface alrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] total_rx;
    logic [63:0] total_tx;
    logic [6:0]  regen_count;
    modport source (output valid, command, total_rx, total_tx, regen_count, input ready);
    modport sink (input valid, command, total_rx, total_tx, regen_count, output ready);
endinterface

interface alrm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_level;
    logic [7:0] tx_level;
    logic [7:0] both_level;
    logic [3:0] scale_select;
    logic       rescaled;
    logic       last;
    modport source (output valid, rx_level, tx_level, both_level, scale_select, rescaled,
                    last, input ready);
    modport sink (input valid, rx_level, tx_level, both_level, scale_select, rescaled,
                  last, output ready);
endinterface

### rtl/alrm_div.sv
// Bit-serial restoring divider: floor(x*255/div), one quotient bit per cycle.
`timescale 1ns / 1ps
module alrm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  alrm_pkg::t_div_ctl                i_ctl,
    input  logic [alrm_pkg::RATE_W-1:0]       i_x,
    input  logic [alrm_pkg::RATE_W-1:0]       i_div,
    output alrm_pkg::t_div_ctl                o_ctl,
    output logic [alrm_pkg::LEVEL_W-1:0]      o_q
);
    logic [alrm_pkg::PROD_W-1:0]  r_dd;
    logic [alrm_pkg::RATE_W:0]    r_r;
    logic [alrm_pkg::RATE_W-1:0]  r_dv;
    logic [alrm_pkg::LEVEL_W-1:0] r_q;
    logic [alrm_pkg::DSTEP_W-1:0] r_cnt;
    logic                         r_done;
    logic                         r_zero;
    logic [alrm_pkg::RATE_W:0]    rs;
    logic                         ge;

    assign rs = {r_r[alrm_pkg::RATE_W-1:0], r_dd[alrm_pkg::PROD_W-1]};
    assign ge = rs >= {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt <= alrm_pkg::DIV_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dd   <= {i_x, 8'd0} - {8'd0, i_x};
            r_r    <= '0;
            r_q    <= '0;
            r_dv   <= i_div;
            r_zero <= i_div == '0;
        end else if (r_cnt != '0) begin
            r_dd <= {r_dd[alrm_pkg::PROD_W-2:0], 1'b0};
            r_r  <= ge ? rs - {1'b0, r_dv} : rs;
            r_q  <= {r_q[alrm_pkg::LEVEL_W-2:0], ge};
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_q         = r_zero ? '0 : r_q;
endmodule

### rtl/alrm_hist.sv
// Rate history memory: one write port, one registered read port.
`timescale 1ns / 1ps
module alrm_hist #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [alrm_pkg::RATE_W-1:0]   i_wrx,
    input  logic [alrm_pkg::RATE_W-1:0]   i_wtx,
    input  logic [AW-1:0]                 i_raddr,
    output logic [alrm_pkg::RATE_W-1:0]   o_rrx,
    output logic [alrm_pkg::RATE_W-1:0]   o_rtx
);
    logic [2*alrm_pkg::RATE_W-1:0] r_mem [DEPTH];
    logic [2*alrm_pkg::RATE_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wrx, i_wtx};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rrx = r_rd[2*alrm_pkg::RATE_W-1:alrm_pkg::RATE_W];
    assign o_rtx = r_rd[alrm_pkg::RATE_W-1:0];
endmodule

### rtl/autoranging_link_rate_meter.sv
// Top level of the autoranging link rate meter.
//
// i_in carries commands with cumulative rx/tx byte totals; o_res carries
// result items (three 0..255 levels, scale index, rescale flag, last).
// i_cfg_we/i_cfg_idx/i_cfg_data write min_peak (0) and decay_shift (1).
// A sample (command 0) gives one result after the transfer: three
// rate/peak levels, each from a 72-step bit-serial divider. A regenerate
// (command 1) gives regen_count results, capped at 64, newest first; a
// stored entry needs a memory read plus three divisions, a zero-filled
// entry neither. A baseline (command 2) gives nothing. One item is worked
// on at a time; i_in.ready is high in idle. Results sit in an output
// register, so a new item can be taken while the last result still
// waits; a stalled receiver holds the next result in the block until the
// register drains. Reset clears totals, peak, scale index, history
// pointer and count and loads the configuration defaults; no clearing
// pass is needed.
`timescale 1ns / 1ps
module autoranging_link_rate_meter #(
    parameter int unsigned HISTORY_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    alrm_in_if.sink                          i_in,
    alrm_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [alrm_pkg::MINPK_W-1:0]     i_cfg_data
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam int unsigned W = alrm_pkg::RATE_W;

    alrm_pkg::t_state r_state, n_state;
    alrm_pkg::t_cmd   r_cmd, n_cmd;
    logic [W-1:0] r_trx, n_trx, r_ttx, n_ttx;
    logic [W-1:0] r_prev_rx, n_prev_rx, r_prev_tx, n_prev_tx;
    logic [W-1:0] r_peak, n_peak, r_total, n_total;
    logic [W-1:0] r_rx, n_rx, r_tx, n_tx;
    logic [3:0]   r_sidx, n_sidx, r_old_idx, n_old_idx;
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_vc, n_vc;
    logic [6:0]   r_n, n_n, r_i, n_i, r_avail, n_avail;
    logic [1:0]   r_sel, n_sel;
    logic [7:0]   r_lrx, n_lrx, r_ltx, n_ltx, r_lb, n_lb;
    logic         r_resc, n_resc;
    logic [alrm_pkg::MINPK_W-1:0] r_minpk;
    logic [alrm_pkg::SHIFT_W-1:0] r_decay;
    logic         r_ov, n_ov;
    logic [7:0]   r_orx, n_orx, r_otx, n_otx, r_ob, n_ob;
    logic [3:0]   r_osel, n_osel;
    logic         r_oresc, n_oresc, r_olast, n_olast;

    logic         hist_we;
    logic [W-1:0] hrx, htx, rate_rx, rate_tx, sum, floor_v, op, dx;
    logic [W:0]   sum_w;
    logic         accept;
    logic         lst;
    alrm_pkg::t_div_ctl div_in, div_out;
    logic [7:0]   div_q;

    alrm_hist #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(r_wp), .i_wrx(rate_rx), .i_wtx(rate_tx),
        .i_raddr(r_rp), .o_rrx(hrx), .o_rtx(htx)
    );

    alrm_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_in), .i_x(dx), .i_div(r_peak),
        .o_ctl(div_out), .o_q(div_q)
    );

    assign rate_rx = (r_trx >= r_prev_rx) ? r_trx - r_prev_rx : '0;
    assign rate_tx = (r_ttx >= r_prev_tx) ? r_ttx - r_prev_tx : '0;
    assign sum_w   = {1'b0, rate_rx} + {1'b0, rate_tx};
    assign sum     = sum_w[W] ? '1 : sum_w[W-1:0];
    assign floor_v = (r_minpk == '0) ? 64'd1 : {{(W-alrm_pkg::MINPK_W){1'b0}}, r_minpk};
    assign accept  = i_in.valid && i_in.ready;
    assign lst     = (r_cmd == alrm_pkg::CMD_SAMPLE) || (r_i + 7'd1 == r_n);

    always_comb begin
        unique case (r_sel)
            2'd0:    op = r_rx;
            2'd1:    op = r_tx;
            default: op = (r_rx < r_tx) ? r_rx : r_tx;
        endcase
        dx = (op > r_peak) ? r_peak : op;
    end

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_trx = r_trx; n_ttx = r_ttx;
        n_prev_rx = r_prev_rx; n_prev_tx = r_prev_tx; n_peak = r_peak; n_total = r_total;
        n_rx = r_rx; n_tx = r_tx; n_sidx = r_sidx; n_old_idx = r_old_idx;
        n_wp = r_wp; n_rp = r_rp; n_vc = r_vc; n_n = r_n; n_i = r_i; n_avail = r_avail;
        n_sel = r_sel; n_lrx = r_lrx; n_ltx = r_ltx; n_lb = r_lb; n_resc = r_resc;
        n_ov = r_ov; n_orx = r_orx; n_otx = r_otx; n_ob = r_ob; n_osel = r_osel;
        n_oresc = r_oresc; n_olast = r_olast;
        hist_we = 1'b0;
        div_in.start = 1'b0;
        div_in.done  = 1'b0;
        i_in.ready = (r_state == alrm_pkg::S_IDLE);
        if (o_res.ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            alrm_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd = alrm_pkg::t_cmd'(i_in.command);
                    n_trx = i_in.total_rx;
                    n_ttx = i_in.total_tx;
                    n_n   = (i_in.regen_count > alrm_pkg::MAX_RESULTS) ?
                            alrm_pkg::MAX_RESULTS : i_in.regen_count;
                    n_i   = '0;
                    n_avail = (r_vc > 1) ? 7'(r_vc - 1'b1) : '0;
                    n_rp  = (r_wp >= AW'(2)) ? r_wp - AW'(2) : r_wp + AW'(HISTORY_DEPTH - 2);
                    unique case (alrm_pkg::t_cmd'(i_in.command))
                        alrm_pkg::CMD_SAMPLE, alrm_pkg::CMD_BASELINE: n_state = alrm_pkg::S_RATE;
                        alrm_pkg::CMD_REGEN: begin
                            if (i_in.regen_count != '0) begin
                                n_state = alrm_pkg::S_RLOAD;
                            end
                        end
                        default: n_state = alrm_pkg::S_IDLE;
                    endcase
                end
            end
            alrm_pkg::S_RATE: begin
                hist_we   = 1'b1;
                n_rx      = rate_rx;
                n_tx      = rate_tx;
                n_total   = sum;
                n_prev_rx = r_trx;
                n_prev_tx = r_ttx;
                n_wp      = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                if (r_vc < DEPTH_C) begin
                    n_vc = r_vc + 1'b1;
                end
                n_old_idx = r_sidx;
                n_state   = alrm_pkg::S_PEAK;
            end
            alrm_pkg::S_PEAK: begin
                if (r_total > r_peak) begin
                    n_peak = r_total;
                    n_sidx = alrm_pkg::ceil_index(r_total);
                end else if (r_peak > alrm_pkg::DECAY_FLOOR) begin
                    n_peak = r_peak - (r_peak >> r_decay);
                    n_sidx = alrm_pkg::ceil_index(n_peak);
                end
                n_state = alrm_pkg::S_FLOOR;
            end
            alrm_pkg::S_FLOOR: begin
                if (r_peak < floor_v) begin
                    n_peak = floor_v;
                    n_sidx = alrm_pkg::ceil_index(floor_v);
                end
                n_resc = (n_sidx != r_old_idx);
                n_sel  = '0;
                if (r_cmd == alrm_pkg::CMD_BASELINE) begin
                    n_peak  = '0;
                    n_wp    = '0;
                    n_vc    = '0;
                    n_state = alrm_pkg::S_IDLE;
                end else begin
                    n_state = alrm_pkg::S_DSTART;
                end
            end
            alrm_pkg::S_RLOAD: begin
                n_resc = 1'b0;
                if (r_i < r_avail) begin
                    n_state = alrm_pkg::S_RWAIT;
                end else begin
                    n_lrx = '0; n_ltx = '0; n_lb = '0;
                    n_state = alrm_pkg::S_EMIT;
                end
            end
            alrm_pkg::S_RWAIT: begin
                n_rx = hrx;
                n_tx = htx;
                n_sel = '0;
                n_state = alrm_pkg::S_DSTART;
            end
            alrm_pkg::S_DSTART: begin
                div_in.start = 1'b1;
                n_state = alrm_pkg::S_DWAIT;
            end
            alrm_pkg::S_DWAIT: begin
                if (div_out.done) begin
                    unique case (r_sel)
                        2'd0:    n_lrx = div_q;
                        2'd1:    n_ltx = div_q;
                        default: n_lb  = div_q;
                    endcase
                    if (r_sel == 2'd2) begin
                        n_state = alrm_pkg::S_EMIT;
                    end else begin
                        n_sel = r_sel + 2'd1;
                        n_state = alrm_pkg::S_DSTART;
                    end
                end
            end
            alrm_pkg::S_EMIT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_orx = r_lrx; n_otx = r_ltx; n_ob = r_lb;
                    n_osel = r_sidx; n_oresc = r_resc; n_olast = lst;
                    if (lst) begin
                        n_state = alrm_pkg::S_IDLE;
                    end else begin
                        n_i  = r_i + 7'd1;
                        n_rp = (r_rp == '0) ? LAST_ADDR : r_rp - 1'b1;
                        n_state = alrm_pkg::S_RLOAD;
                    end
                end
            end
            default: n_state = alrm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alrm_pkg::S_IDLE;
            r_prev_rx <= '0; r_prev_tx <= '0; r_peak <= '0; r_sidx <= '0;
            r_wp <= '0; r_vc <= '0; r_ov <= 1'b0;
            r_minpk <= alrm_pkg::MIN_PEAK_RST;
            r_decay <= alrm_pkg::DECAY_RST;
        end else begin
            r_state <= n_state;
            r_prev_rx <= n_prev_rx; r_prev_tx <= n_prev_tx; r_peak <= n_peak;
            r_sidx <= n_sidx; r_wp <= n_wp; r_vc <= n_vc; r_ov <= n_ov;
            if (i_cfg_we) begin
                unique case (alrm_pkg::t_cfg_idx'(i_cfg_idx))
                    alrm_pkg::CFG_MIN_PEAK:    r_minpk <= i_cfg_data;
                    alrm_pkg::CFG_DECAY_SHIFT: r_decay <= i_cfg_data[alrm_pkg::SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_trx <= n_trx; r_ttx <= n_ttx; r_total <= n_total;
        r_rx <= n_rx; r_tx <= n_tx; r_old_idx <= n_old_idx; r_rp <= n_rp;
        r_n <= n_n; r_i <= n_i; r_avail <= n_avail; r_sel <= n_sel;
        r_lrx <= n_lrx; r_ltx <= n_ltx; r_lb <= n_lb; r_resc <= n_resc;
        r_orx <= n_orx; r_otx <= n_otx; r_ob <= n_ob; r_osel <= n_osel;
        r_oresc <= n_oresc; r_olast <= n_olast;
    end

    assign o_res.valid        = r_ov;
    assign o_res.rx_level     = r_orx;
    assign o_res.tx_level     = r_otx;
    assign o_res.both_level   = r_ob;
    assign o_res.scale_select = r_osel;
    assign o_res.rescaled     = r_oresc;
    assign o_res.last         = r_olast;
endmodule
